[src/spmf_pkg.sv]
package spmf_pkg;

	localparam int DATA_W   = 32;
	localparam int CMD_W    = 3;
	localparam int LEVEL_W  = 4;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = 4;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_BACK   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd4;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BADPRIO  = 2'd3;

	// Decision made by the pointer table for one command.
	typedef struct packed {
		logic                ram_we;
		logic                ram_re;
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
		logic                all_empty;
	} spmf_op_t;

endpackage

[src/spmf_if.sv]
interface spmf_req_if;
	import spmf_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         cmd;
	logic signed [DATA_W-1:0] data_in;
	logic [LEVEL_W-1:0]       level;

	modport source (output valid, output cmd, output data_in, output level, input ready);
	modport sink (input valid, input cmd, input data_in, input level, output ready);
endinterface

interface spmf_rsp_if;
	import spmf_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] data_out;
	logic [STATUS_W-1:0]      status;
	logic [SLOT_W-1:0]        slot;
	logic                     all_empty;

	modport source (output valid, output data_out, output status, output slot,
		output all_empty, input ready);
	modport sink (input valid, input data_out, input status, input slot,
		input all_empty, output ready);
endinterface

[src/spmf_ram.sv]
module spmf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/spmf_ptrs.sv]
module spmf_ptrs #(
	parameter int LEVELS = 8,
	parameter int DEPTH  = 16
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        commit,
	input  logic [spmf_pkg::CMD_W-1:0]                  cmd,
	input  logic [spmf_pkg::LEVEL_W-1:0]                level,
	output logic [$clog2(LEVELS*DEPTH)-1:0]             addr,
	output spmf_pkg::spmf_op_t                          op
);
	import spmf_pkg::*;

	localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int PW = $clog2(DEPTH);
	localparam int AW = $clog2(LEVELS*DEPTH);

	logic [LEVELS-1:0] ne_q;
	logic [LEVELS-1:0] ne_d;
	logic [PW-1:0]     head_q [LEVELS];
	logic [PW-1:0]     tail_q [LEVELS];

	logic [LW-1:0] first_lvl;
	logic [LW-1:0] last_lvl;
	logic [LW-1:0] sel_q;
	logic          any_busy;
	logic          lvl_ok;
	logic [PW-1:0] sel_head;
	logic [PW-1:0] sel_tail;
	logic [PW-1:0] next_tail;
	logic [PW-1:0] ptr_sel;
	logic          wr_head;
	logic          wr_tail;
	logic [PW-1:0] new_head;
	logic [PW-1:0] new_tail;

	function automatic logic [PW-1:0] wrap_next(input logic [PW-1:0] p);
		return (p == PW'(DEPTH-1)) ? '0 : p + 1'b1;
	endfunction

	// Priority encoders: lowest busy index is the highest priority.
	always_comb begin
		first_lvl = '0;
		for (int i = LEVELS-1; i >= 0; i--) begin
			if (ne_q[i]) first_lvl = LW'(i);
		end
	end

	always_comb begin
		last_lvl = '0;
		for (int i = 0; i < LEVELS; i++) begin
			if (ne_q[i]) last_lvl = LW'(i);
		end
	end

	assign any_busy = |ne_q;
	assign lvl_ok   = (level != '0) && (level <= LEVEL_W'(LEVELS));

	always_comb begin
		unique case (cmd)
			CMD_INSERT: sel_q = LW'(level - 4'd1);
			CMD_BACK:   sel_q = last_lvl;
			default:    sel_q = first_lvl;
		endcase
	end

	assign sel_head  = head_q[sel_q];
	assign sel_tail  = tail_q[sel_q];
	assign next_tail = wrap_next(sel_tail);

	always_comb begin
		op        = '0;
		op.status = ST_OK;
		ne_d      = ne_q;
		ptr_sel   = '0;
		wr_head   = 1'b0;
		wr_tail   = 1'b0;
		new_head  = '0;
		new_tail  = '0;
		case (cmd) inside
			CMD_INSERT: begin
				if (!lvl_ok) begin
					op.status = ST_BADPRIO;
				end else if (!ne_q[sel_q]) begin
					ne_d[sel_q] = 1'b1;
					wr_head     = 1'b1;
					wr_tail     = 1'b1;
					op.ram_we   = 1'b1;
				end else if (next_tail == sel_head) begin
					op.status = ST_OVERFLOW;
				end else begin
					wr_tail   = 1'b1;
					new_tail  = next_tail;
					ptr_sel   = next_tail;
					op.ram_we = 1'b1;
					op.slot   = SLOT_W'(next_tail);
				end
			end
			CMD_POP, CMD_PEEK: begin
				if (!any_busy) begin
					op.status = ST_EMPTY;
				end else begin
					op.ram_re = 1'b1;
					ptr_sel   = sel_head;
					if (cmd == CMD_POP) begin
						if (sel_head == sel_tail) begin
							// Last entry leaves: the level rewinds to slot zero.
							ne_d[sel_q] = 1'b0;
							wr_head     = 1'b1;
							wr_tail     = 1'b1;
						end else begin
							wr_head  = 1'b1;
							new_head = wrap_next(sel_head);
						end
					end
				end
			end
			CMD_BACK: begin
				if (!any_busy) begin
					op.status = ST_EMPTY;
				end else begin
					op.ram_re = 1'b1;
					ptr_sel   = sel_tail;
				end
			end
			default: begin
			end
		endcase
		op.all_empty = ~|ne_d;
	end

	assign addr = AW'(sel_q) * AW'(DEPTH) + AW'(ptr_sel);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ne_q <= '0;
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
		end else if (commit) begin
			ne_q <= ne_d;
			if (wr_head) head_q[sel_q] <= new_head;
			if (wr_tail) tail_q[sel_q] <= new_tail;
		end
	end

endmodule

[src/strict_priority_multi_fifo_core.sv]
// Strict-priority queue of LEVELS circular FIFOs, each DEPTH entries deep.
// Level 1 is the highest priority.
//
// Commands arrive as beats on the req channel (cmd, data_in, level) and each
// one produces exactly one beat on the rsp channel (data_out, status, slot,
// all_empty). A command is taken when req.valid and req.ready are both high.
//
// Insert, query, error and undefined commands show their response in the cycle
// after acceptance. Pop, peek and back load the entry memory read register at
// the acceptance edge and then pass through one wait state of the sequencer
// before their response appears.
// With rsp.ready held high a new command is taken in the same cycle that the
// previous response is taken, so non-reading commands sustain one per cycle;
// a reading command blocks new commands during its wait state, the limit.
//
// If the receiver stalls, the response stays registered and req.ready stays
// low until the response beat completes.
// Reset empties every level and rewinds all head and tail pointers; the entry
// memory itself is not cleared and needs no clearing pass.
module strict_priority_multi_fifo_core #(
	parameter int LEVELS = 8,
	parameter int DEPTH  = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	spmf_req_if.sink   req,
	spmf_rsp_if.source rsp
);
	import spmf_pkg::*;

	localparam int ENTRIES = LEVELS * DEPTH;
	localparam int AW      = $clog2(ENTRIES);

	// One-hot sequencer: idle, waiting on the memory read, holding a response.
	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_WAIT = 3'b010,
		S_OUT  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	logic              accept;
	logic [AW-1:0]     ram_addr;
	logic [DATA_W-1:0] ram_rdata;
	spmf_op_t          op;

	// Response fields that are known at acceptance time.
	logic [STATUS_W-1:0] status_q;
	logic [SLOT_W-1:0]   slot_q;
	logic                all_empty_q;
	logic                from_ram_q;

	// A new command may enter once the pending response is leaving.
	assign req.ready = (state_q == S_IDLE) || ((state_q == S_OUT) && rsp.ready);
	assign accept    = req.valid && req.ready;

	spmf_ptrs #(
		.LEVELS (LEVELS),
		.DEPTH  (DEPTH)
	) u_ptrs (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (accept),
		.cmd    (req.cmd),
		.level  (req.level),
		.addr   (ram_addr),
		.op     (op)
	);

	// Insert writes and reads share one address; a command never does both.
	// Writes land at the acceptance edge, so any later read sees them.
	spmf_ram #(
		.WIDTH (DATA_W),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (accept && op.ram_we),
		.waddr (ram_addr),
		.wdata (DATA_W'(req.data_in)),
		.re    (accept && op.ram_re),
		.raddr (ram_addr),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = op.ram_re ? S_WAIT : S_OUT;
			end
			S_WAIT: state_d = S_OUT;
			S_OUT: begin
				if (accept) begin
					state_d = op.ram_re ? S_WAIT : S_OUT;
				end else if (rsp.ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= op.status;
			slot_q      <= op.slot;
			all_empty_q <= op.all_empty;
			from_ram_q  <= op.ram_re;
		end
	end

	// The memory read register holds its value until the next read, which
	// can only be issued when this response is taken.
	assign rsp.valid     = (state_q == S_OUT);
	assign rsp.data_out  = from_ram_q ? signed'(ram_rdata) : '0;
	assign rsp.status    = status_q;
	assign rsp.slot      = slot_q;
	assign rsp.all_empty = all_empty_q;

	a_read_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op.ram_re) |=> !rsp.valid)
		else $error("response shown before memory read data returned");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status == ST_EMPTY)) |-> rsp.all_empty)
		else $error("empty status reported while a level holds entries");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && ((rsp.status == ST_OVERFLOW) || (rsp.status == ST_BADPRIO)))
		|-> ((rsp.slot == '0) && (rsp.data_out == '0)))
		else $error("failed insert reported a slot or data");

	a_one_ram_access: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !(op.ram_we && op.ram_re))
		else $error("command both writes and reads the entry memory");

endmodule
